/* hw/rtl/assm_pkg.sv */
// shared types, constants and lookup functions for the averaged sensor display mux
package assm_pkg;

    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned SCALE_W  = 20;
    localparam int unsigned SUM_W    = 12;
    localparam int unsigned VALUE_W  = 14;
    localparam int unsigned SEG_W    = 8;
    localparam int unsigned PHASE_W  = 2;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned QUOT_W   = 5;
    localparam int unsigned QUOT_MAX = 16;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned PROD_W   = SAMPLE_W + SCALE_W;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd704682;

    // tick phases with special meaning
    localparam logic [PHASE_W-1:0] PHASE_THOUSANDS = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_POINT     = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_TENS      = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_REFRESH   = 2'd3;

    // accepted input item held in the input register
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] adc_sample;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [SEG_W-1:0]    segments;
        logic [PHASE_W-1:0]  digit_select;
        logic [SAMPLE_W-1:0] average_value;
    } t_result;

    // active-low segment patterns, bit 0 is the decimal point
    function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] pat;
        case (digit)
            4'd0:    pat = 8'h03;
            4'd1:    pat = 8'h9F;
            4'd2:    pat = 8'h25;
            4'd3:    pat = 8'h0D;
            4'd4:    pat = 8'h99;
            4'd5:    pat = 8'h49;
            4'd6:    pat = 8'h41;
            4'd7:    pat = 8'h1B;
            4'd8:    pat = 8'h01;
            4'd9:    pat = 8'h09;
            default: pat = 8'hFF;
        endcase
        return pat;
    endfunction

    // decimal weight of the digit shown in each phase
    function automatic logic [VALUE_W-1:0] digit_weight(input logic [PHASE_W-1:0] phase);
        logic [VALUE_W-1:0] w;
        case (phase)
            PHASE_THOUSANDS: w = 14'd1000;
            PHASE_POINT:     w = 14'd100;
            PHASE_TENS:      w = 14'd10;
            PHASE_REFRESH:   w = 14'd1;
            default:         w = 14'd1;
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/averaged_sensor_seven_segment_mux.sv */
// top level of the averaged sensor four-digit seven-segment display mux
//
// Each input item is one display tick carrying a 10-bit converter sample
// (i_valid / o_ready). Each tick yields exactly one result item on
// o_valid / i_ready: the active-low segment pattern of the digit now lit,
// the digit index (0 is the thousands digit) and the current four-sample
// average. Every fourth tick the average is refreshed and the scaled value
// floor(avg * scale_q16 / 65536) becomes the new set of displayed digits.
// The scale is written through i_cfg_we / i_cfg_data; the user must write
// it only while the block idles, as the block itself does not enforce this.
// Each accepted item passes through the input register, then the result
// register, before it appears on the outputs. Throughput: one item per
// cycle while the receiver does not stall; the digit of each tick is peeled
// off the scaled value by one combinational compare bank.
// Reset (synchronous, active low) empties both registers, clears phase,
// sum, average and digits, and loads the default scale.
// When the receiver stalls the result register holds its item; the input
// register still takes one more item, after which o_ready drops.
module averaged_sensor_seven_segment_mux (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [assm_pkg::SAMPLE_W-1:0]    i_adc_sample,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [assm_pkg::SEG_W-1:0]       o_segments,
    output logic [assm_pkg::PHASE_W-1:0]     o_digit_select,
    output logic [assm_pkg::SAMPLE_W-1:0]    o_average_value,
    input  logic                             i_cfg_we,
    input  logic [assm_pkg::SCALE_W-1:0]     i_cfg_data
);
    import assm_pkg::*;

    t_in_item item;
    t_result  result;
    t_result  r_out;
    logic     r_out_valid;
    logic     advance;
    logic     fire;

    // result register can take a new item when empty or being drained
    assign advance = !r_out_valid || i_ready;
    assign fire    = item.valid && advance;

    // input register
    assm_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_adc_sample (i_adc_sample),
        .i_advance    (advance),
        .o_ready      (o_ready),
        .o_item       (item)
    );

    // datapath and state
    assm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (item),
        .i_fire     (fire),
        .o_result   (result)
    );

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= item.valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_segments      = r_out.segments;
    assign o_digit_select  = r_out.digit_select;
    assign o_average_value = r_out.average_value;

endmodule

/* hw/rtl/assm_in_reg.sv */
// input register stage: holds one accepted item until the core takes it
module assm_in_reg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [assm_pkg::SAMPLE_W-1:0]    i_adc_sample,
    input  logic                             i_advance,
    output logic                             o_ready,
    output assm_pkg::t_in_item               o_item
);
    import assm_pkg::*;

    logic                r_valid;
    logic [SAMPLE_W-1:0] r_sample;

    // free when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_advance;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sample <= i_adc_sample;
        end
    end

    assign o_item = '{valid: r_valid, adc_sample: r_sample};

endmodule

/* hw/rtl/assm_core.sv */
// display core: tick phase, sample averaging, scaled value and digit extraction
module assm_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [assm_pkg::SCALE_W-1:0]     i_cfg_data,
    input  assm_pkg::t_in_item               i_item,
    input  logic                             i_fire,
    output assm_pkg::t_result                o_result
);
    import assm_pkg::*;

    logic [SCALE_W-1:0]  r_scale;
    logic [PHASE_W-1:0]  r_phase;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_avg;
    logic [VALUE_W-1:0]  r_rem;

    logic [PHASE_W-1:0]  n_phase;
    logic [SUM_W-1:0]    n_sum;
    logic [SAMPLE_W-1:0] n_avg;
    logic [VALUE_W-1:0]  n_rem;

    logic [VALUE_W-1:0]  weight;
    logic [VALUE_W-1:0]  multiple;
    logic [VALUE_W-1:0]  taken;
    logic [QUOT_W-1:0]   quot;
    logic [DIGIT_W-1:0]  digit;
    logic [SEG_W-1:0]    seg;
    logic [PROD_W-1:0]   product;
    logic [SUM_W-1:0]    sum_in;

    // scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_data;
        end
    end

    // pick the digit of this phase off the remaining value by parallel compares
    always_comb begin
        n_phase = r_phase + 2'd1;
        weight  = digit_weight(n_phase);
        quot    = '0;
        taken   = '0;
        for (int k = 1; k <= QUOT_MAX; k++) begin
            multiple = VALUE_W'(QUOT_W'(k) * weight);
            if (r_rem >= multiple) begin
                quot  = QUOT_W'(k);
                taken = multiple;
            end
        end
        digit = (quot >= QUOT_W'(10)) ? DIGIT_W'(quot - QUOT_W'(10)) : DIGIT_W'(quot);
    end

    // segment pattern with decimal point on digit 1
    always_comb begin
        seg = seg_pattern(digit);
        if (n_phase == PHASE_POINT) begin
            seg[0] = 1'b0;
        end
    end

    // accumulate, and on the refresh phase average and rescale
    always_comb begin
        sum_in  = r_sum + SUM_W'(i_item.adc_sample);
        n_avg   = r_avg;
        n_sum   = sum_in;
        n_rem   = r_rem - taken;
        product = PROD_W'(sum_in[SUM_W-1:2]) * PROD_W'(r_scale);
        if (n_phase == PHASE_REFRESH) begin
            n_avg = sum_in[SUM_W-1:2];
            n_sum = '0;
            n_rem = product[FRAC_W +: VALUE_W];
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_sum   <= '0;
            r_avg   <= '0;
            r_rem   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_avg   <= n_avg;
            r_rem   <= n_rem;
        end
    end

    assign o_result = '{segments: seg, digit_select: n_phase, average_value: n_avg};

endmodule

/* hw/rtl/assm_checker.sv */
// port-level checker for the display mux, bound to the top level
module assm_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             o_valid,
    input  logic                             i_ready,
    input  logic [assm_pkg::SEG_W-1:0]       o_segments,
    input  logic [assm_pkg::PHASE_W-1:0]     o_digit_select,
    input  logic [assm_pkg::SAMPLE_W-1:0]    o_average_value
);
    import assm_pkg::*;

    logic                r_seen;
    logic [PHASE_W-1:0]  r_last_sel;
    logic [SAMPLE_W-1:0] r_last_avg;
    logic                out_fire;

    assign out_fire = o_valid && i_ready;

    // remember the last delivered item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= 1'b0;
            r_last_sel <= '0;
            r_last_avg <= '0;
        end else if (out_fire) begin
            r_seen     <= 1'b1;
            r_last_sel <= o_digit_select;
            r_last_avg <= o_average_value;
        end
    end

    // the first item after reset lights digit 1, then the digit steps by one
    a_digit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire |-> o_digit_select == (r_seen ? r_last_sel + 2'd1 : PHASE_POINT))
        else $error("digit select did not step by one");

    // decimal point lit exactly on digit 1
    a_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_segments[0] == 1'b0) == (o_digit_select == PHASE_POINT)))
        else $error("decimal point on wrong digit");

    // the average only moves on the refresh tick
    a_avg_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && r_seen && o_average_value != r_last_avg)
            |-> o_digit_select == PHASE_REFRESH)
        else $error("average changed off the refresh tick");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_segments)
            && $stable(o_digit_select) && $stable(o_average_value)))
        else $error("stalled result changed");

endmodule

bind averaged_sensor_seven_segment_mux assm_checker u_assm_checker (.*);

/* tb/tb_averaged_sensor_seven_segment_mux.sv */
// self-checking testbench for the averaged sensor seven-segment display mux
module tb_averaged_sensor_seven_segment_mux;
    timeunit 1ns;
    timeprecision 1ps;

    import assm_pkg::*;

    localparam int LONG_HOLD      = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [SAMPLE_W-1:0] i_adc_sample;
    logic                o_valid;
    logic                i_ready;
    logic [SEG_W-1:0]    o_segments;
    logic [PHASE_W-1:0]  o_digit_select;
    logic [SAMPLE_W-1:0] o_average_value;
    logic                i_cfg_we;
    logic [SCALE_W-1:0]  i_cfg_data;

    averaged_sensor_seven_segment_mux i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_adc_sample    (i_adc_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_segments      (o_segments),
        .o_digit_select  (o_digit_select),
        .o_average_value (o_average_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    // display model state
    logic [SCALE_W-1:0]  mdl_scale;
    logic [PHASE_W-1:0]  mdl_phase;
    logic [SUM_W-1:0]    mdl_sum;
    logic [SAMPLE_W-1:0] mdl_avg;
    logic [DIGIT_W-1:0]  mdl_digits [4];
    logic [SEG_W-1:0]    digit_segments [0:9] = '{8'h03, 8'h9F, 8'h25, 8'h0D, 8'h99,
                                                  8'h49, 8'h41, 8'h1B, 8'h01, 8'h09};

    t_result predicted_ticks [$];

    int errors;
    int ticks_sent;
    int results_checked;
    int scales_written;
    int holds_asked;
    int holds_taken;
    int idle_cycles;
    bit rx_steady;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // random gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        else if (roll < 90) return $urandom_range(1, 3);
        else return $urandom_range(8, 40);
    endfunction

    // sample mix leaning on the range ends
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_W'($urandom_range(1000, 1023));
            default: return SAMPLE_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // advance the display model by one tick and queue its result
    task automatic model_tick(input logic [SAMPLE_W-1:0] sample);
        t_result           r;
        logic [PROD_W-1:0] prod;
        int unsigned       v;
        mdl_phase = mdl_phase + 1'b1;
        r.segments = digit_segments[mdl_digits[mdl_phase]];
        if (mdl_phase == PHASE_POINT) r.segments[0] = 1'b0;
        mdl_sum = mdl_sum + {2'b00, sample};
        if (mdl_phase == PHASE_REFRESH) begin
            mdl_avg = mdl_sum[SUM_W-1:2];
            mdl_sum = '0;
            prod = mdl_avg * mdl_scale;
            v = prod >> FRAC_W;
            mdl_digits[0] = DIGIT_W'((v / 1000) % 10);
            mdl_digits[1] = DIGIT_W'((v / 100) % 10);
            mdl_digits[2] = DIGIT_W'((v / 10) % 10);
            mdl_digits[3] = DIGIT_W'(v % 10);
        end
        r.digit_select  = mdl_phase;
        r.average_value = mdl_avg;
        predicted_ticks.push_back(r);
    endtask

    // offer one sample and hold it until accepted
    task automatic send_tick(input logic [SAMPLE_W-1:0] sample);
        @(negedge i_clk);
        i_valid      = 1'b1;
        i_adc_sample = sample;
        do @(posedge i_clk); while (!o_ready);
        model_tick(sample);
        ticks_sent++;
    endtask

    task automatic sender_idle(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // stop sending and let every predicted result come out
    task automatic wait_for_results();
        sender_idle(1);
        while (predicted_ticks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        mdl_scale  = value;
        scales_written++;
    endtask

    // default scale, first short average, range ends, large and zero scale
    task automatic test_directed();
        repeat (3) send_tick('1);
        send_tick('0);
        send_tick(SAMPLE_W'(512));
        send_tick(SAMPLE_W'(1));
        send_tick('1);
        wait_for_results();
        // thousands digit wraps modulo 10 with the largest scale
        write_scale('1);
        repeat (8) send_tick('1);
        wait_for_results();
        write_scale('0);
        repeat (4) send_tick('0);
        wait_for_results();
    endtask

    // random samples and gaps under a series of scale settings
    task automatic test_scale_sweep();
        logic [SCALE_W-1:0] scale;
        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       scale = SCALE_W'(65536);
                1:       scale = SCALE_W'($urandom_range(0, 1048575));
                2:       scale = SCALE_W'($urandom_range(1, 4096));
                3:       scale = '1;
                default: scale = SCALE_RESET;
            endcase
            write_scale(scale);
            repeat (195) begin
                sender_idle(pick_gap());
                send_tick(pick_sample());
            end
            wait_for_results();
        end
    endtask

    // back-to-back items with the receiver always ready
    task automatic test_full_rate();
        rx_steady = 1'b1;
        repeat (100) send_tick(pick_sample());
        rx_steady = 1'b0;
        wait_for_results();
    endtask

    // receiver stalls for a long stretch while items keep coming
    task automatic test_output_stall();
        holds_asked++;
        repeat (20) send_tick(pick_sample());
        wait_for_results();
    endtask

    // sender pauses mid-stream until everything has drained
    task automatic test_sender_pause();
        repeat (20) begin
            sender_idle(pick_gap());
            send_tick(pick_sample());
        end
        wait_for_results();
        repeat (20) begin
            sender_idle(pick_gap());
            send_tick(pick_sample());
        end
        wait_for_results();
    endtask

    // result receiver with random stalls and one-shot long holds
    initial begin : result_receiver
        int idle_left;
        idle_left = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_asked != holds_taken) begin
                holds_taken++;
                idle_left = LONG_HOLD;
            end
            if (idle_left > 0) begin
                i_ready = 1'b0;
                idle_left--;
            end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
                i_ready   = 1'b0;
                idle_left = pick_gap();
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    task automatic check_field(input string field, input logic [SAMPLE_W-1:0] want,
                               input logic [SAMPLE_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    // compare each result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (predicted_ticks.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, actual seg %h digit %0d avg %0d",
                         $time, o_segments, o_digit_select, o_average_value);
            end else begin
                want = predicted_ticks.pop_front();
                check_field("segments", SAMPLE_W'(want.segments), SAMPLE_W'(o_segments));
                check_field("digit_select", SAMPLE_W'(want.digit_select),
                            SAMPLE_W'(o_digit_select));
                check_field("average_value", want.average_value, o_average_value);
                results_checked++;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_adc_sample = '0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        errors          = 0;
        ticks_sent      = 0;
        results_checked = 0;
        scales_written  = 0;
        holds_asked     = 0;
        holds_taken     = 0;
        idle_cycles     = 0;
        rx_steady       = 1'b0;
        mdl_scale = SCALE_RESET;
        mdl_phase = '0;
        mdl_sum   = '0;
        mdl_avg   = '0;
        for (int i = 0; i < 4; i++) mdl_digits[i] = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_scale_sweep();
        test_full_rate();
        test_output_stall();
        test_sender_pause();

        while (predicted_ticks.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (predicted_ticks.size() != 0) errors++;

        $display("run covered %0d ticks and %0d checked results over %0d scale writes,",
                 ticks_sent, results_checked, scales_written);
        $display("including a long output stall, a drained pause and a full-rate burst");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
